@@ src/cmli_pkg.sv @@
`timescale 1ns / 1ps

package cmli_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int LEVEL_W       = 16;
  localparam int CHAN_W        = 16;  // ROM entries are UQ0.16
  localparam int COLOR_W       = 8;
  localparam int NUM_CH        = 3;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [COLOR_W-1:0] color_t;

  localparam chan_t RED_ROM [TABLE_ENTRIES] = '{
    16'd18505, 16'd19479, 16'd20138, 16'd20469, 16'd20472, 16'd20171, 16'd19617, 16'd18878,
    16'd18029, 16'd17133, 16'd16235, 16'd15353, 16'd14475, 16'd13573, 16'd12608, 16'd11552,
    16'd10414, 16'd9293,  16'd8449,  16'd8348,  16'd9449,  16'd11833, 16'd15235, 16'd19372,
    16'd24046, 16'd29132, 16'd34538, 16'd40171, 16'd45918, 16'd51637, 16'd57187, 16'd62456
  };

  localparam chan_t GREEN_ROM [TABLE_ENTRIES] = '{
    16'd0,     16'd1781,  16'd5259,  16'd8247,  16'd11062, 16'd13776, 16'd16391, 16'd18898,
    16'd21292, 16'd23580, 16'd25774, 16'd27897, 16'd29969, 16'd32011, 16'd34038, 16'd36062,
    16'd38088, 16'd40112, 16'd42127, 16'd44120, 16'd46073, 16'd47965, 16'd49776, 16'd51481,
    16'd53056, 16'd54479, 16'd55730, 16'd56801, 16'd57698, 16'd58456, 16'd59134, 16'd59805
  };

  localparam chan_t BLUE_ROM [TABLE_ENTRIES] = '{
    16'd21693, 16'd24815, 16'd27608, 16'd30015, 16'd31992, 16'd33529, 16'd34657, 16'd35436,
    16'd35947, 16'd36267, 16'd36458, 16'd36564, 16'd36605, 16'd36579, 16'd36466, 16'd36234,
    16'd35844, 16'd35251, 16'd34413, 16'd33295, 16'd31868, 16'd30108, 16'd27998, 16'd25525,
    16'd22679, 16'd19451, 16'd15832, 16'd11821, 16'd7473,  16'd3298,  16'd2872,  16'd7265
  };

  function automatic chan_t rom_read(input int ch, input idx_t idx);
    chan_t val;
    unique case (ch)
      CH_RED:   val = RED_ROM[idx];
      CH_GREEN: val = GREEN_ROM[idx];
      default:  val = BLUE_ROM[idx];
    endcase
    return val;
  endfunction

endpackage

@@ src/colormap_linear_interpolation.sv @@
`timescale 1ns / 1ps

// Viridis false-color mapper. Each item carries a level in unsigned fixed
// point with LEVEL_FRACTION_BITS fraction bits (Q1.15 by default, 32768 is
// 1.0); levels at or above 1.0 give the last table color. The level picks a
// segment of a 32-entry color ROM and red, green and blue are interpolated
// linearly (signed, so falling channels fall) and scaled by 255, truncated.
// Four register stages: scale by 31, ROM lookup, interpolate, scale by 255.
// One item per clock when the output is not stalled.
// A stall on the output freezes the whole pipe; in_stall follows
// out_valid && out_stall combinationally.
module colormap_linear_interpolation #(
  parameter int LEVEL_FRACTION_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cmli_pkg::LEVEL_W-1:0]  in_s_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cmli_pkg::COLOR_W-1:0]  out_red,
  output logic [cmli_pkg::COLOR_W-1:0]  out_green,
  output logic [cmli_pkg::COLOR_W-1:0]  out_blue
);

  localparam int F      = LEVEL_FRACTION_BITS;
  localparam int IW     = cmli_pkg::IDX_W;
  localparam int CW     = cmli_pkg::CHAN_W;
  localparam int OW     = cmli_pkg::COLOR_W;
  localparam int NCH    = cmli_pkg::NUM_CH;
  // level width wide enough to hold 1.0
  localparam int LW     = (F + 1 > cmli_pkg::LEVEL_W) ? F + 1 : cmli_pkg::LEVEL_W;
  localparam int PW     = LW + IW;          // level * (entries - 1)
  localparam int VW     = CW + F;           // interpolated channel, UQ0.(16+F)
  localparam int SW     = VW + 2;           // signed interpolation sum
  localparam int XW     = VW + OW;          // channel * 255
  localparam int LAST   = cmli_pkg::TABLE_ENTRIES - 1;

  localparam logic [LW-1:0] ONE      = LW'(1) << F;
  localparam logic [PW-1:0] LAST_SEG = PW'(LAST);

  // global advance: a full output register that is stalled holds every stage
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------------------------------------------------------------
  // Stage 1: saturation check and p = level * (entries - 1)
  // ---------------------------------------------------------------------
  logic            v1_r;
  logic            sat1_r;
  logic [PW-1:0]   p1_r;
  logic [LW-1:0]   lvl_ext;
  logic            sat1_nxt;
  logic [PW-1:0]   p1_nxt;

  always_comb begin
    lvl_ext  = LW'(in_s_level);
    sat1_nxt = (lvl_ext >= ONE);
    p1_nxt   = PW'(lvl_ext) * PW'(LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
    if (adv) begin
      sat1_r <= sat1_nxt;
      p1_r   <= p1_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: segment select and ROM lookup of both segment ends.
  // Saturated levels read the last entry at both ends with zero fraction,
  // which reduces the interpolation to that entry exactly.
  // ---------------------------------------------------------------------
  logic                v2_r;
  cmli_pkg::chan_t     c0_r [NCH];
  cmli_pkg::chan_t     c1_r [NCH];
  logic [F-1:0]        frac2_r;
  cmli_pkg::chan_t     c0_nxt [NCH];
  cmli_pkg::chan_t     c1_nxt [NCH];
  logic [F-1:0]        frac2_nxt;
  logic [PW-1:0]       seg_full;
  cmli_pkg::idx_t      ia;
  cmli_pkg::idx_t      ib;

  always_comb begin
    seg_full = p1_r >> F;
    priority if (sat1_r) begin
      ia        = IW'(LAST);
      frac2_nxt = '0;
    end else if (seg_full >= LAST_SEG) begin
      // unreachable below 1.0; clamp to the last segment
      ia        = IW'(LAST - 1);
      frac2_nxt = '1;
    end else begin
      ia        = seg_full[IW-1:0];
      frac2_nxt = p1_r[F-1:0];
    end
    ib = sat1_r ? ia : ia + IW'(1);
    for (int ch = 0; ch < NCH; ch++) begin
      c0_nxt[ch] = cmli_pkg::rom_read(ch, ia);
      c1_nxt[ch] = cmli_pkg::rom_read(ch, ib);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      frac2_r <= frac2_nxt;
      for (int ch = 0; ch < NCH; ch++) begin
        c0_r[ch] <= c0_nxt[ch];
        c1_r[ch] <= c1_nxt[ch];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: v = c0 * 2^F + (c1 - c0) * f, one signed multiply per channel
  // ---------------------------------------------------------------------
  logic              v3_r;
  logic [VW-1:0]     lerp_r [NCH];
  logic [VW-1:0]     lerp_nxt [NCH];
  logic signed [CW:0]     diff;
  logic signed [CW+F+1:0] prod;
  logic signed [SW-1:0]   sum;

  always_comb begin
    diff = '0;
    prod = '0;
    sum  = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      diff = $signed({1'b0, c1_r[ch]}) - $signed({1'b0, c0_r[ch]});
      prod = diff * $signed({1'b0, frac2_r});
      sum  = $signed({2'b00, c0_r[ch], {F{1'b0}}}) + SW'(prod);
      lerp_nxt[ch] = sum[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      for (int ch = 0; ch < NCH; ch++) begin
        lerp_r[ch] <= lerp_nxt[ch];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: (v * 255) >> (16 + F). v < 2^(16+F), so the top byte never
  // needs clamping.
  // ---------------------------------------------------------------------
  logic              out_valid_r;
  cmli_pkg::color_t  color_r [NCH];
  cmli_pkg::color_t  color_nxt [NCH];
  logic [XW-1:0]     scaled;

  always_comb begin
    scaled = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      scaled = {lerp_r[ch], {OW{1'b0}}} - XW'(lerp_r[ch]);
      color_nxt[ch] = scaled[XW-1 -: OW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v3_r;
    end
    if (adv) begin
      for (int ch = 0; ch < NCH; ch++) begin
        color_r[ch] <= color_nxt[ch];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = color_r[cmli_pkg::CH_RED];
  assign out_green = color_r[cmli_pkg::CH_GREEN];
  assign out_blue  = color_r[cmli_pkg::CH_BLUE];

endmodule
